// ===== rtl/float32_square_root_macros.svh =====
// Assertion macros for the square root block
`ifndef FLOAT32_SQUARE_ROOT_MACROS_SVH
`define FLOAT32_SQUARE_ROOT_MACROS_SVH
`ifndef SYNTH
`define FSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/fsq_pkg.sv =====
// ----------------------------------------------------------------------------
// fsq_pkg
// Shared types, constants and the reciprocal square root seed table.
// ----------------------------------------------------------------------------
`default_nettype none
package fsq_pkg;

  localparam logic [1:0] RM_NEAREST = 2'd0;
  localparam logic [1:0] RM_ZERO    = 2'd1;
  localparam logic [1:0] RM_UP      = 2'd2;
  localparam logic [1:0] RM_DOWN    = 2'd3;

  localparam logic [31:0] THREE_HALVES = 32'hc000_0000;
  localparam logic [31:0] QNAN         = 32'h7fc0_0000;
  localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
  localparam logic [31:0] POS_INF      = 32'h7f80_0000;
  localparam logic [31:0] MIN_NORM     = 32'h0080_0000;
  localparam logic [31:0] ONE_BITS     = 32'h3f80_0000;

  // Special results decided up front, carried down the pipe
  typedef struct packed {
    logic        special;
    logic [31:0] bits;
    logic        invalid;
  } special_t;

  // Pipeline data between stages
  typedef struct packed {
    special_t    sp;
    logic [1:0]  rm;
    logic [31:0] m;
    logic [31:0] ey;
    logic [31:0] r;
    logic [31:0] s;
    logic [31:0] u;
  } pipe_t;

  function automatic logic [15:0] rsqrt_seed(input logic [6:0] idx);
    logic [15:0] t [128];
    t = '{
      16'hb451,16'hb2f0,16'hb196,16'hb044,16'haef9,16'hadb6,16'hac79,16'hab43,
      16'haa14,16'ha8eb,16'ha7c8,16'ha6aa,16'ha592,16'ha480,16'ha373,16'ha26b,
      16'ha168,16'ha06a,16'h9f70,16'h9e7b,16'h9d8a,16'h9c9d,16'h9bb5,16'h9ad1,
      16'h99f0,16'h9913,16'h983a,16'h9765,16'h9693,16'h95c4,16'h94f8,16'h9430,
      16'h936b,16'h92a9,16'h91ea,16'h912e,16'h9075,16'h8fbe,16'h8f0a,16'h8e59,
      16'h8daa,16'h8cfe,16'h8c54,16'h8bac,16'h8b07,16'h8a64,16'h89c4,16'h8925,
      16'h8889,16'h87ee,16'h8756,16'h86c0,16'h862b,16'h8599,16'h8508,16'h8479,
      16'h83ec,16'h8361,16'h82d8,16'h8250,16'h81c9,16'h8145,16'h80c2,16'h8040,
      16'hff02,16'hfd0e,16'hfb25,16'hf947,16'hf773,16'hf5aa,16'hf3ea,16'hf234,
      16'hf087,16'heee3,16'hed47,16'hebb3,16'hea27,16'he8a3,16'he727,16'he5b2,
      16'he443,16'he2dc,16'he17a,16'he020,16'hdecb,16'hdd7d,16'hdc34,16'hdaf1,
      16'hd9b3,16'hd87b,16'hd748,16'hd61a,16'hd4f1,16'hd3cd,16'hd2ad,16'hd192,
      16'hd07b,16'hcf69,16'hce5b,16'hcd51,16'hcc4a,16'hcb48,16'hca4a,16'hc94f,
      16'hc858,16'hc764,16'hc674,16'hc587,16'hc49d,16'hc3b7,16'hc2d4,16'hc1f4,
      16'hc116,16'hc03c,16'hbf65,16'hbe90,16'hbdbe,16'hbcef,16'hbc23,16'hbb59,
      16'hba91,16'hb9cc,16'hb90a,16'hb84a,16'hb78c,16'hb6d0,16'hb617,16'hb560};
    return t[idx];
  endfunction

  function automatic logic [31:0] mul_hi(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[63:32];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fsq_front.sv =====
// ----------------------------------------------------------------------------
// fsq_front
// Classify the operand, normalise subnormals, form mantissa, exponent, seed.
// ----------------------------------------------------------------------------
`default_nettype none
module fsq_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_vld,
  input  wire logic [31:0]      ix_in,
  input  wire logic [1:0]       rm_in,
  output logic                  vld_r,
  output fsq_pkg::pipe_t        d_r
);
  import fsq_pkg::*;

  logic [31:0] nb;
  logic [4:0]  p;
  logic [31:0] ix;
  logic        is_odd;
  logic [31:0] frac;
  pipe_t       d_nxt;

  // Find the leading one of a subnormal mantissa
  always_comb begin
    p = 5'd0;
    for (int i = 1; i <= 22; i++) begin
      if (ix_in[i]) p = 5'(i);
    end
  end

  always_comb begin
    frac = (ix_in << (5'd23 - p)) & 32'h007f_ffff;
    nb   = (({27'd0, p} + 32'd1) << 23 | frac) - (32'd23 << 23);
    d_nxt = '0;
    d_nxt.rm = rm_in;
    ix = ix_in;
    if (ix_in - MIN_NORM >= POS_INF - MIN_NORM) begin
      if (ix_in[30:0] == 31'd0 || ix_in == POS_INF) begin
        d_nxt.sp = '{special: 1'b1, bits: ix_in, invalid: 1'b0};
      end else if (ix_in[30:0] > POS_INF[30:0]) begin
        d_nxt.sp = '{special: 1'b1, bits: ix_in | QUIET_BIT, invalid: ~ix_in[22]};
      end else if (ix_in[31]) begin
        d_nxt.sp = '{special: 1'b1, bits: QNAN, invalid: 1'b1};
      end else begin
        ix = nb;
      end
    end
    is_odd  = ix[23];
    d_nxt.m = is_odd ? ((ix << 7) & 32'h7fff_ffff) : ((ix << 8) | 32'h8000_0000);
    d_nxt.ey = ((ix >> 1) + (ONE_BITS >> 1)) & POS_INF;
    d_nxt.r = {rsqrt_seed(ix[23:17]), 16'd0};
  end

  // Register stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    d_r <= d_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/fsq_gs_stage.sv =====
// ----------------------------------------------------------------------------
// fsq_gs_stage
// One Goldschmidt pipeline step, selected by a fixed step code input.
// ----------------------------------------------------------------------------
`default_nettype none
module fsq_gs_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [2:0]       step,
  input  wire logic             vld_in,
  input  wire fsq_pkg::pipe_t   d_in,
  output logic                  vld_r,
  output fsq_pkg::pipe_t        d_r
);
  import fsq_pkg::*;

  pipe_t d_nxt;

  // Each step uses at most one level of 32x32 multiplies
  always_comb begin
    d_nxt = d_in;
    case (step)
      3'd0: d_nxt.s = mul_hi(d_in.m, d_in.r);
      3'd1: d_nxt.u = THREE_HALVES - mul_hi(d_in.s, d_in.r);
      3'd2: begin
        d_nxt.r = mul_hi(d_in.r, d_in.u) << 1;
        d_nxt.s = mul_hi(d_in.s, d_in.u) << 1;
      end
      3'd3: d_nxt.u = THREE_HALVES - mul_hi(d_in.s, d_in.r);
      3'd4: d_nxt.s = (mul_hi(d_in.s, d_in.u) - 32'd1) >> 6;
      default: d_nxt = d_in;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    d_r <= d_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/fsq_round.sv =====
// ----------------------------------------------------------------------------
// fsq_round
// Remainder check, rounding and result register, over two stages.
// ----------------------------------------------------------------------------
`default_nettype none
module fsq_round (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             vld_in,
  input  wire fsq_pkg::pipe_t   d_in,
  output logic                  vld_r,
  output logic [31:0]           root_r,
  output logic                  invalid_r,
  output logic                  inexact_r
);
  import fsq_pkg::*;

  logic        v1_r;
  pipe_t       p1_r;
  logic [31:0] rem_r;
  logic [63:0] sq;
  logic [31:0] d1, d2, s2, root;
  logic        below, inex;

  // Square the truncated root and hold the remainder
  assign sq = {32'd0, d_in.s} * {32'd0, d_in.s};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= vld_in;
    end
    p1_r  <= d_in;
    rem_r <= (d_in.m << 16) - sq[31:0];
  end

  // Round to nearest, then step for directed modes
  always_comb begin
    d1 = p1_r.s - rem_r;
    d2 = d1 + p1_r.s + 32'd1;
    s2 = p1_r.s + {31'd0, d1[31]};
    root = (s2 & 32'h007f_ffff) | p1_r.ey;
    inex = (d2 != 32'd0);
    below = ~(d1[31] ^ d2[31]);
    if (inex) begin
      case (p1_r.rm)
        RM_UP:            if (below) root = root + 32'd1;
        RM_ZERO, RM_DOWN: if (!below) root = root - 32'd1;
        default:          root = root;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= v1_r;
    end
    root_r    <= p1_r.sp.special ? p1_r.sp.bits : root;
    invalid_r <= p1_r.sp.special & p1_r.sp.invalid;
    inexact_r <= ~p1_r.sp.special & inex;
  end
endmodule
`default_nettype wire

// ===== rtl/float32_square_root.sv =====
// ----------------------------------------------------------------------------
// float32_square_root
// Pipelined correctly rounded binary32 square root.
// ----------------------------------------------------------------------------
// Usage: raise start with in_operand_bits; busy is always low, so one
// operand is taken every cycle. After the transfer the result appears on
// out_root_bits, out_invalid_flag and out_inexact_flag for one cycle with
// out_strobe high. Throughput is one item per cycle; each item passes
// through the front stage, five Goldschmidt multiply stages and two rounding
// stages. cfg_we writes cfg_rounding_mode; the mode travels with each item.
// Synchronous reset clears the valid bits and sets nearest-even rounding.
// The receiver cannot stall, so no back-pressure exists inside the pipe.
// ----------------------------------------------------------------------------
`default_nettype none
`include "float32_square_root_macros.svh"
module float32_square_root (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_operand_bits,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_rounding_mode,
  output logic             out_strobe,
  output logic [31:0]      out_root_bits,
  output logic             out_invalid_flag,
  output logic             out_inexact_flag
);
  import fsq_pkg::*;

  logic [1:0] rm_r;
  logic       v [6];
  pipe_t      d [6];

  assign busy = 1'b0;

  // Hold the rounding mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rm_r <= RM_NEAREST;
    end else if (cfg_we) begin
      rm_r <= cfg_rounding_mode;
    end
  end

  fsq_front u_front (.clk, .rst_n, .in_vld(start & ~busy), .ix_in(in_operand_bits),
                     .rm_in(rm_r), .vld_r(v[0]), .d_r(d[0]));

  for (genvar g = 0; g < 5; g++) begin : g_gs
    fsq_gs_stage u_gs (.clk, .rst_n, .step(3'(g)), .vld_in(v[g]), .d_in(d[g]),
                       .vld_r(v[g+1]), .d_r(d[g+1]));
  end

  fsq_round u_round (.clk, .rst_n, .vld_in(v[5]), .d_in(d[5]), .vld_r(out_strobe),
                     .root_r(out_root_bits), .invalid_r(out_invalid_flag),
                     .inexact_r(out_inexact_flag));

  // Check flags against the strobe and result pattern; the rounding unit is two stages deep
  `FSQ_ASSERT_IMPL(a_flags_excl, clk, rst_n, out_strobe, !(out_invalid_flag && out_inexact_flag))
  `FSQ_ASSERT_IMPL(a_invalid_nan, clk, rst_n, out_strobe && out_invalid_flag, out_root_bits[30:22] == 9'h1ff)
  `FSQ_ASSERT_NEXT(a_pipe_step, clk, rst_n, v[5], ##1 out_strobe)
endmodule
`default_nettype wire

// ===== test/float32_square_root_tb.sv =====
// ----------------------------------------------------------------------------
// float32_square_root_tb
// Drives binary32 operands into the square root pipe under every rounding
// mode, predicts each root and its flags, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module float32_square_root_tb;
  import fsq_pkg::*;

  localparam int LATENCY   = 8;
  localparam int MAX_CYCLE = 200000;

  typedef struct packed {
    logic [31:0] bits;
    logic        invalid;
    logic        inexact;
  } root_t;

  typedef struct {
    logic [31:0] operand;
    logic        known;
    root_t       want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_operand_bits = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_rounding_mode = RM_NEAREST;
  logic        out_strobe;
  logic [31:0] out_root_bits;
  logic        out_invalid_flag;
  logic        out_inexact_flag;

  logic [1:0] mode_model = RM_NEAREST;
  root_t      pending_roots[$];
  int         errors = 0;
  int         cycles = 0;

  float32_square_root u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operand_bits(in_operand_bits),
    .cfg_we(cfg_we), .cfg_rounding_mode(cfg_rounding_mode),
    .out_strobe(out_strobe), .out_root_bits(out_root_bits),
    .out_invalid_flag(out_invalid_flag), .out_inexact_flag(out_inexact_flag)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort on a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [15:0] seed_of(input logic [6:0] idx);
    logic [15:0] t [128];
    t = '{
      16'hb451,16'hb2f0,16'hb196,16'hb044,16'haef9,16'hadb6,16'hac79,16'hab43,
      16'haa14,16'ha8eb,16'ha7c8,16'ha6aa,16'ha592,16'ha480,16'ha373,16'ha26b,
      16'ha168,16'ha06a,16'h9f70,16'h9e7b,16'h9d8a,16'h9c9d,16'h9bb5,16'h9ad1,
      16'h99f0,16'h9913,16'h983a,16'h9765,16'h9693,16'h95c4,16'h94f8,16'h9430,
      16'h936b,16'h92a9,16'h91ea,16'h912e,16'h9075,16'h8fbe,16'h8f0a,16'h8e59,
      16'h8daa,16'h8cfe,16'h8c54,16'h8bac,16'h8b07,16'h8a64,16'h89c4,16'h8925,
      16'h8889,16'h87ee,16'h8756,16'h86c0,16'h862b,16'h8599,16'h8508,16'h8479,
      16'h83ec,16'h8361,16'h82d8,16'h8250,16'h81c9,16'h8145,16'h80c2,16'h8040,
      16'hff02,16'hfd0e,16'hfb25,16'hf947,16'hf773,16'hf5aa,16'hf3ea,16'hf234,
      16'hf087,16'heee3,16'hed47,16'hebb3,16'hea27,16'he8a3,16'he727,16'he5b2,
      16'he443,16'he2dc,16'he17a,16'he020,16'hdecb,16'hdd7d,16'hdc34,16'hdaf1,
      16'hd9b3,16'hd87b,16'hd748,16'hd61a,16'hd4f1,16'hd3cd,16'hd2ad,16'hd192,
      16'hd07b,16'hcf69,16'hce5b,16'hcd51,16'hcc4a,16'hcb48,16'hca4a,16'hc94f,
      16'hc858,16'hc764,16'hc674,16'hc587,16'hc49d,16'hc3b7,16'hc2d4,16'hc1f4,
      16'hc116,16'hc03c,16'hbf65,16'hbe90,16'hbdbe,16'hbcef,16'hbc23,16'hbb59,
      16'hba91,16'hb9cc,16'hb90a,16'hb84a,16'hb78c,16'hb6d0,16'hb617,16'hb560};
    return t[idx];
  endfunction

  function automatic logic [31:0] high_half(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[63:32];
  endfunction

  // Square root of one pattern under the current rounding mode
  function automatic root_t square_root(input logic [31:0] op, input logic [1:0] rm);
    root_t       res;
    logic [31:0] x, m, ey, r, s, d, u, rem, d1, d2, root;
    logic [63:0] sq;
    int          p;
    logic        below;
    res = '0;
    x = op;
    if (x - MIN_NORM >= POS_INF - MIN_NORM) begin
      if (x[30:0] == 31'd0 || x == POS_INF) begin
        res.bits = x;
        return res;
      end
      if (x[30:0] > POS_INF[30:0]) begin
        res.bits = x | QUIET_BIT;
        res.invalid = ~x[22];
        return res;
      end
      if (x[31]) begin
        res.bits = QNAN;
        res.invalid = 1'b1;
        return res;
      end
      // Normalise the subnormal, exponent field lowered by 23
      p = 22;
      while (p > 0 && !x[p]) p--;
      x = ((32'(p + 1) << 23) | ((x << (23 - p)) & 32'h007f_ffff)) - (32'd23 << 23);
    end
    m  = x[23] ? ((x << 7) & 32'h7fff_ffff) : ((x << 8) | 32'h8000_0000);
    ey = ((x >> 1) + (ONE_BITS >> 1)) & POS_INF;
    r = {seed_of(x[23:17]), 16'd0};
    s = high_half(m, r);
    d = high_half(s, r);
    u = THREE_HALVES - d;
    r = high_half(r, u) << 1;
    s = high_half(s, u) << 1;
    d = high_half(s, r);
    u = THREE_HALVES - d;
    s = high_half(s, u);
    s = (s - 32'd1) >> 6;
    sq  = {32'd0, s} * {32'd0, s};
    rem = (m << 16) - sq[31:0];
    d1  = s - rem;
    d2  = d1 + s + 32'd1;
    s   = s + {31'd0, d1[31]};
    root = (s & 32'h007f_ffff) | ey;
    if (d2 != 32'd0) begin
      below = ((d1 ^ d2) & 32'h8000_0000) == 32'd0;
      res.inexact = 1'b1;
      if (rm == RM_UP) begin
        if (below) root = root + 32'd1;
      end else if (rm == RM_ZERO || rm == RM_DOWN) begin
        if (!below) root = root - 32'd1;
      end
    end
    res.bits = root;
    return res;
  endfunction

  // Compare each strobed result with the oldest expected root
  always @(posedge clk) begin
    root_t got, want;
    if (rst_n && out_strobe) begin
      got = '{out_root_bits, out_invalid_flag, out_inexact_flag};
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_roots.pop_front();
        if (got.bits !== want.bits) begin
          $display("%0t: root exp %h got %h", $time, want.bits, got.bits);
          errors++;
        end
        if (got.invalid !== want.invalid) begin
          $display("%0t: invalid exp %b got %b", $time, want.invalid, got.invalid);
          errors++;
        end
        if (got.inexact !== want.inexact) begin
          $display("%0t: inexact exp %b got %b", $time, want.inexact, got.inexact);
          errors++;
        end
      end
    end
  end

  // Present one operand and hold until the transfer
  task automatic send_operand(input logic [31:0] op, input logic known, input root_t want,
                              input int idle_pct);
    root_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operand_bits <= op;
    predicted = square_root(op, mode_model);
    if (known && predicted !== want) begin
      $display("%0t: table row %h exp %h predictor %h", $time, op, want, predicted);
      errors++;
    end
    pending_roots.push_back(predicted);
    do @(posedge clk); while (busy);
  endtask

  // Drain the pipe, then write the rounding mode
  task automatic set_mode(input logic [1:0] rm);
    start <= 1'b0;
    @(posedge clk);
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_rounding_mode <= rm;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_model = rm;
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0: v[30:23] = 8'hff;
      1: v[30:23] = 8'h00;
      2: v[31] = 1'b1;
      default: v[31] = 1'b0;
    endcase
    return v;
  endfunction

  row_t table_rows[$];

  initial begin
    int idle;
    table_rows = '{
      '{32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
      '{32'h8000_0000, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
      '{32'h7f80_0000, 1'b1, '{32'h7f80_0000, 1'b0, 1'b0}},
      '{32'hff80_0000, 1'b1, '{QNAN, 1'b1, 1'b0}},
      '{32'hbf80_0000, 1'b1, '{QNAN, 1'b1, 1'b0}},
      '{32'h8000_0001, 1'b1, '{QNAN, 1'b1, 1'b0}},
      '{32'h7fc0_0000, 1'b1, '{32'h7fc0_0000, 1'b0, 1'b0}},
      '{32'h7f80_0001, 1'b1, '{32'h7fc0_0001, 1'b1, 1'b0}},
      '{32'hffbf_ffff, 1'b1, '{32'hffff_ffff, 1'b1, 1'b0}},
      '{32'hffff_ffff, 1'b1, '{32'hffff_ffff, 1'b0, 1'b0}},
      '{32'h3f80_0000, 1'b1, '{32'h3f80_0000, 1'b0, 1'b0}},
      '{32'h4080_0000, 1'b1, '{32'h4000_0000, 1'b0, 1'b0}},
      '{32'h4000_0000, 1'b0, '0},
      '{32'h0000_0001, 1'b0, '0},
      '{32'h007f_ffff, 1'b0, '0},
      '{32'h0040_0000, 1'b0, '0},
      '{32'h0080_0000, 1'b0, '0},
      '{32'h7f7f_ffff, 1'b0, '0},
      '{32'h3fff_ffff, 1'b0, '0},
      '{32'h4040_0000, 1'b0, '0}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under every mode, reset mode first
    for (int md = 0; md < 4; md++) begin
      if (md != 0) set_mode(2'(md));
      foreach (table_rows[i])
        send_operand(table_rows[i].operand, table_rows[i].known && md == 0,
                     table_rows[i].want, 0);
    end

    // Random operands: two sender idle phases, then none
    for (int n = 0; n < 1950; n++) begin
      if (n % 240 == 0) set_mode(2'($urandom_range(3)));
      idle = (n < 1000) ? 13 : ((n < 1500) ? 68 : 0);
      if (n == 700) begin
        // Hold off until the pipe has emptied
        start <= 1'b0;
        @(posedge clk);
        while (pending_roots.size() != 0) @(posedge clk);
      end
      send_operand(random_operand(), 1'b0, '0, idle);
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
